/* rtl/core/ecspm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecspm_pkg
// Shared types, register indexes, mode codes and Q16.16 saturation helper
// for the element-wise sum / product / maximum combiner.
// ----------------------------------------------------------------------------
package ecspm_pkg;

    localparam int MAX_INPUTS_DEF = 4;
    localparam int DATA_W         = 32;
    localparam int MODE_W         = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int NUM_COEFF      = 4;
    localparam int OUT_TDATA_W    = 40;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef q16_t [NUM_COEFF-1:0]     coeff_set_t;

    localparam q16_t Q_ONE = 32'sd65536;
    localparam q16_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q_MIN = 32'sh8000_0000;

    localparam logic [MODE_W-1:0] MODE_PROD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SUM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_ZERO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_THREE = 3'd4;

    typedef struct packed {
        q16_t acc;
        logic clip;
        logic excess;
    } acc_state_t;

    typedef struct packed {
        q16_t value;
        logic clip;
    } sat_t;

    function automatic sat_t sat32(input logic signed [48:0] v);
        sat_t r;
        r.clip  = (v[48:31] != {18{v[48]}});
        r.value = r.clip ? (v[48] ? Q_MIN : Q_MAX) : q16_t'(v[31:0]);
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/elementwise_combine_sum_prod_max.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// elementwise_combine_sum_prod_max
// Streams the operands of one output position and emits one combined result
// per position (product, weighted sum or maximum with winner index), Q16.16.
// ----------------------------------------------------------------------------
// One operand is taken every cycle, with no gap between positions, unless a
// tlast operand waits for the master side to take the previous result. An operand
// sits in an input register and, unless it waits so, is folded in the next cycle
// through one 32x32 multiply, a 49-bit add and saturation, a tlast one into the output register.
// The accumulator loop (multiply, add, saturate) sets the clock period. Write
// configuration only while the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module elementwise_combine_sum_prod_max #(
    parameter int MAX_INPUTS = ecspm_pkg::MAX_INPUTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [ecspm_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] operand_value
    input  wire logic                            s_axis_tlast,   // is_last
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [31:0] result_value, [33:32] winner_index, [34] saturated, [35] too_many
    output logic [ecspm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ecspm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ecspm_pkg::DATA_W-1:0]    cfg_data
);
    import ecspm_pkg::*;

    localparam int CNT_W = $clog2(MAX_INPUTS + 1);

    logic [MODE_W-1:0] mode_reg;
    coeff_set_t        coeff_reg;

    logic              in_valid_reg;
    q16_t              in_operand_reg;
    logic              in_last_reg;

    acc_state_t        state_reg;
    acc_state_t        state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  best_reg;
    logic [CNT_W-1:0]  best_next;

    acc_state_t        step_state;
    logic [CNT_W-1:0]  step_count;
    logic [CNT_W-1:0]  step_best;

    logic              out_valid_reg;
    logic              out_valid_next;
    q16_t              out_value_reg;
    logic [1:0]        out_winner_reg;
    logic              out_clip_reg;
    logic              out_excess_reg;

    logic              out_free;
    logic              step_go;
    logic              emit;

    ecspm_combine #(
        .MAX_INPUTS (MAX_INPUTS),
        .CNT_W      (CNT_W)
    ) u_combine (
        .mode      (mode_reg),
        .coeff     (coeff_reg),
        .operand   (in_operand_reg),
        .cur       (state_reg),
        .cur_count (count_reg),
        .cur_best  (best_reg),
        .nxt       (step_state),
        .nxt_count (step_count),
        .nxt_best  (step_best)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step_go       = in_valid_reg && (!in_last_reg || out_free);
    assign emit          = step_go && in_last_reg;
    assign s_axis_tready = !in_valid_reg || step_go;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_excess_reg, out_clip_reg, out_winner_reg, out_value_reg};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (step_go)
        begin
            if (in_last_reg)
            begin
                state_next     = '0;
                count_next     = '0;
                best_next      = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                state_next = step_state;
                count_next = step_count;
                best_next  = step_best;
            end
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SUM;
            coeff_reg <= {NUM_COEFF{Q_ONE}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:        mode_reg     <= cfg_data[MODE_W-1:0];
                REG_COEFF_ZERO:  coeff_reg[0] <= cfg_data;
                REG_COEFF_ONE:   coeff_reg[1] <= cfg_data;
                REG_COEFF_TWO:   coeff_reg[2] <= cfg_data;
                REG_COEFF_THREE: coeff_reg[3] <= cfg_data;
                default:         ;
            endcase
        end
    end

    // control and position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            count_reg     <= '0;
            best_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            count_reg     <= count_next;
            best_reg      <= best_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_operand_reg <= s_axis_tdata;
            in_last_reg    <= s_axis_tlast;
        end
        if (emit)
        begin
            out_value_reg  <= step_state.acc;
            out_winner_reg <= (mode_reg == MODE_MAX) ? step_best[1:0] : 2'b0;
            out_clip_reg   <= step_state.clip;
            out_excess_reg <= step_state.excess;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_INPUTS))
        else $error("operand count beyond limit");

    a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (best_reg == '0 && !state_reg.clip && !state_reg.excess))
        else $error("position state not cleared");

    a_excess_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.excess |-> (count_reg == CNT_W'(MAX_INPUTS)))
        else $error("excess flag without full count");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("result lost after last operand");
`endif

endmodule
`default_nettype wire

/* rtl/core/ecspm_combine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ecspm_combine
// Combinational step of the running accumulator: folds one operand into the
// position state under the current mode.
// ----------------------------------------------------------------------------
module ecspm_combine #(
    parameter int MAX_INPUTS = ecspm_pkg::MAX_INPUTS_DEF,
    parameter int CNT_W      = $clog2(MAX_INPUTS + 1)
) (
    input  wire logic [ecspm_pkg::MODE_W-1:0] mode,
    input  wire ecspm_pkg::coeff_set_t        coeff,
    input  wire ecspm_pkg::q16_t              operand,
    input  wire ecspm_pkg::acc_state_t        cur,
    input  wire logic [CNT_W-1:0]             cur_count,
    input  wire logic [CNT_W-1:0]             cur_best,
    output ecspm_pkg::acc_state_t             nxt,
    output logic [CNT_W-1:0]                  nxt_count,
    output logic [CNT_W-1:0]                  nxt_best
);
    import ecspm_pkg::*;

    logic               over;
    logic               first;
    q16_t               weight;
    q16_t               mul_a;
    logic signed [63:0] prod;
    logic signed [47:0] prod_q;
    q16_t               base;
    logic signed [48:0] total;
    sat_t               sat;
    logic               win;

    always_comb
    begin
        over   = (cur_count >= CNT_W'(MAX_INPUTS));
        first  = (cur_count == '0);
        weight = (int'(cur_count) < NUM_COEFF) ? $signed(coeff[cur_count[1:0]]) : Q_ONE;
        mul_a  = (mode == MODE_PROD) ? cur.acc : weight;
        prod   = $signed(mul_a) * $signed(operand);
        prod_q = prod[63:16];
        base   = (mode != MODE_PROD && !first) ? cur.acc : '0;
        total  = 49'($signed(base)) + 49'($signed(prod_q));
        sat    = sat32(total);
        win    = first || (cur_count == CNT_W'(1) && operand >= cur.acc)
                 || (cur_count >= CNT_W'(2) && operand > cur.acc);

        nxt       = cur;
        nxt_count = cur_count;
        nxt_best  = cur_best;
        if (over)
        begin
            nxt.excess = 1'b1;
        end
        else
        begin
            nxt_count = cur_count + CNT_W'(1);
            case (mode)
                MODE_PROD:
                begin
                    if (first)
                    begin
                        nxt.acc = operand;
                    end
                    else
                    begin
                        nxt.acc  = sat.value;
                        nxt.clip = cur.clip | sat.clip;
                    end
                end
                MODE_MAX:
                begin
                    if (win)
                    begin
                        nxt.acc  = operand;
                        nxt_best = cur_count;
                    end
                end
                default:
                begin
                    nxt.acc  = sat.value;
                    nxt.clip = cur.clip | sat.clip;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the element-wise sum / product / maximum combiner.
// A directed table covers reset defaults, saturation, tie-breaking, excess
// operands and a mode change inside a position. Randomised phases follow,
// with idle cycles on both streams. Results are checked against the expected
// values of typed table rows or a Q16.16 behavioural model kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    import ecspm_pkg::*;

    localparam int                     MAX_IN     = MAX_INPUTS_DEF;
    localparam int                     SETTLE     = 6;
    localparam int                     LIMIT      = 400000;
    localparam logic [MODE_W-1:0]      MODE_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0]   REG_SPARE  = 3'd7;

    typedef struct packed {
        q16_t       value;
        logic [1:0] winner;
        logic       sat;
        logic       excess;
    } outcome_t;

    typedef enum logic {ROW_OPERAND, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    data;
        logic                 last;
        logic                 typed;
        outcome_t             want;
    } step_row_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [DATA_W-1:0]      cfg_data      = '0;

    logic [MODE_W-1:0]      cur_mode;
    q16_t                   weight [NUM_COEFF];
    q16_t                   run_acc;
    int                     run_taken;
    logic [1:0]             run_best;
    logic                   run_clipped;
    logic                   run_excess;

    outcome_t               position_results [$];
    step_row_t              plan [$];
    int                     errors = 0;
    int                     cycles = 0;
    logic                   calm   = 1'b0;

    elementwise_combine_sum_prod_max dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 27);
    end

    function automatic longint qmul(input q16_t a, input q16_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> 16;
    endfunction

    function automatic q16_t saturate(input longint v);
        if (v > longint'(Q_MAX))
        begin
            run_clipped = 1'b1;
            return Q_MAX;
        end
        if (v < longint'(Q_MIN))
        begin
            run_clipped = 1'b1;
            return Q_MIN;
        end
        return q16_t'(v);
    endfunction

    function automatic void clear_position();
        run_acc     = '0;
        run_taken   = 0;
        run_best    = '0;
        run_clipped = 1'b0;
        run_excess  = 1'b0;
    endfunction

    function automatic logic fold_operand(input q16_t x, input logic last,
                                          output outcome_t r);
        q16_t   w;
        longint base;
        r = '0;
        if (run_taken >= MAX_IN)
            run_excess = 1'b1;
        else
        begin
            case (cur_mode)
                MODE_PROD:
                    run_acc = (run_taken == 0) ? x : saturate(qmul(run_acc, x));
                MODE_MAX:
                    if (run_taken == 0 || (run_taken == 1 && x >= run_acc) ||
                        (run_taken >= 2 && x > run_acc))
                    begin
                        run_acc  = x;
                        run_best = run_taken[1:0];
                    end
                default:
                begin
                    w       = (run_taken < NUM_COEFF) ? weight[run_taken] : Q_ONE;
                    base    = (run_taken == 0) ? 0 : longint'(run_acc);
                    run_acc = saturate(base + qmul(w, x));
                end
            endcase
            run_taken++;
        end
        if (!last)
            return 1'b0;
        r.value  = run_acc;
        r.winner = (cur_mode == MODE_MAX) ? run_best : 2'd0;
        r.sat    = run_clipped;
        r.excess = run_excess;
        clear_position();
        return 1'b1;
    endfunction

    function automatic step_row_t operand_row(input q16_t v, input logic last);
        step_row_t r;
        r      = '0;
        r.kind = ROW_OPERAND;
        r.data = v;
        r.last = last;
        return r;
    endfunction

    function automatic step_row_t typed_row(input q16_t v, input logic last,
                                            input q16_t val, input logic [1:0] win,
                                            input logic sat, input logic many);
        step_row_t r;
        r             = operand_row(v, last);
        r.typed       = 1'b1;
        r.want.value  = val;
        r.want.winner = win;
        r.want.sat    = sat;
        r.want.excess = many;
        return r;
    endfunction

    function automatic step_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [DATA_W-1:0] val);
        step_row_t r;
        r      = '0;
        r.kind = ROW_WRITE;
        r.idx  = idx;
        r.data = val;
        return r;
    endfunction

    function automatic q16_t pick_operand();
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return q16_t'($urandom);
            4:       return '0;
            5:       return q16_t'(int'(Q_ONE) + int'($urandom_range(0, 8192)) - 4096);
            default: return q16_t'(int'($urandom_range(0, 524288)) - 262144);
        endcase
    endfunction

    function automatic q16_t pick_weight();
        case ($urandom_range(0, 5))
            0:       return Q_ONE;
            1:       return Q_MAX;
            2:       return Q_MIN;
            3:       return q16_t'($urandom);
            default: return q16_t'(int'($urandom_range(0, 262144)) - 131072);
        endcase
    endfunction

    task automatic send_operand(input q16_t v, input logic last, input logic typed,
                                input outcome_t fixed);
        outcome_t got;
        logic     emits;
        while (!calm && $urandom_range(0, 99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        emits = fold_operand(v, last, got);
        if (emits)
            position_results.push_back(typed ? fixed : got);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (position_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MODE:        cur_mode  = val[MODE_W-1:0];
            REG_COEFF_ZERO:  weight[0] = val;
            REG_COEFF_ONE:   weight[1] = val;
            REG_COEFF_TWO:   weight[2] = val;
            REG_COEFF_THREE: weight[3] = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic flag_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] seen);
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, seen);
        errors++;
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (position_results.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got %h",
                         $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = position_results.pop_front();
                if (m_axis_tdata[31:0] !== want.value)
                    flag_field("result_value", want.value, m_axis_tdata[31:0]);
                if (m_axis_tdata[33:32] !== want.winner)
                    flag_field("winner_index", want.winner, m_axis_tdata[33:32]);
                if (m_axis_tdata[34] !== want.sat)
                    flag_field("saturated", want.sat, m_axis_tdata[34]);
                if (m_axis_tdata[35] !== want.excess)
                    flag_field("too_many", want.excess, m_axis_tdata[35]);
            end
        end
    end

    initial
    begin
        int       len;
        int       sent;
        outcome_t none;
        none      = '0;
        cur_mode  = MODE_SUM;
        for (int i = 0; i < NUM_COEFF; i++)
            weight[i] = Q_ONE;
        clear_position();

        plan.push_back(typed_row(32'h0003_0000, 1'b1, 32'h0003_0000, 2'd0, 1'b0, 1'b0));
        plan.push_back(operand_row(Q_MAX, 1'b0));
        plan.push_back(typed_row(Q_MAX, 1'b1, Q_MAX, 2'd0, 1'b1, 1'b0));
        plan.push_back(write_row(REG_MODE, 32'(MODE_PROD)));
        plan.push_back(operand_row(Q_MAX, 1'b0));
        plan.push_back(typed_row(Q_MAX, 1'b1, Q_MAX, 2'd0, 1'b1, 1'b0));
        plan.push_back(operand_row(Q_MIN, 1'b0));
        plan.push_back(typed_row(Q_MAX, 1'b1, Q_MIN, 2'd0, 1'b1, 1'b0));
        plan.push_back(typed_row(32'hFFFF_8000, 1'b1, 32'hFFFF_8000, 2'd0, 1'b0, 1'b0));
        plan.push_back(write_row(REG_MODE, 32'(MODE_MAX)));
        plan.push_back(operand_row(Q_ONE, 1'b0));
        plan.push_back(operand_row(Q_ONE, 1'b0));
        plan.push_back(typed_row(Q_ONE, 1'b1, Q_ONE, 2'd1, 1'b0, 1'b0));
        plan.push_back(operand_row(32'hFFFF_FFFB, 1'b0));
        plan.push_back(operand_row(Q_MIN, 1'b0));
        plan.push_back(typed_row(Q_MAX, 1'b1, Q_MAX, 2'd2, 1'b0, 1'b0));
        plan.push_back(operand_row(32'd1, 1'b0));
        plan.push_back(operand_row(32'd2, 1'b0));
        plan.push_back(operand_row(32'd3, 1'b0));
        plan.push_back(operand_row(32'd4, 1'b0));
        plan.push_back(typed_row(32'd100, 1'b1, 32'd4, 2'd3, 1'b0, 1'b1));
        // leave a position open across a switch from maximum to the spare mode code
        plan.push_back(operand_row(32'h0002_0000, 1'b0));
        plan.push_back(write_row(REG_MODE, {30'h2969_6969, MODE_SPARE}));
        plan.push_back(operand_row(Q_ONE, 1'b1));
        plan.push_back(write_row(REG_COEFF_ZERO, Q_MIN));
        plan.push_back(write_row(REG_COEFF_ONE, Q_MAX));
        plan.push_back(write_row(REG_COEFF_TWO, 32'd0));
        plan.push_back(write_row(REG_COEFF_THREE, 32'hFFFF_0000));
        plan.push_back(write_row(REG_SPARE, 32'hFFFF_FFFF));
        plan.push_back(operand_row(Q_MAX, 1'b0));
        plan.push_back(operand_row(Q_MIN, 1'b0));
        plan.push_back(operand_row(32'h0005_0000, 1'b0));
        plan.push_back(operand_row(32'h0007_0000, 1'b1));
        plan.push_back(operand_row(32'h0001_8000, 1'b1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_WRITE)
                write_reg(plan[k].idx, plan[k].data);
            else
                send_operand(plan[k].data, plan[k].last, plan[k].typed, plan[k].want);
        end

        for (int ph = 0; ph < 12; ph++)
        begin
            calm = (ph == 7);
            write_reg(REG_MODE, {($urandom_range(0, 1) ? 30'($urandom) : 30'd0),
                                 ((ph % 7 == 6) ? MODE_SPARE : MODE_W'(ph % 3))});
            for (int r = REG_COEFF_ZERO; r <= REG_COEFF_THREE; r++)
                if (ph == 0 || $urandom_range(0, 1))
                    write_reg(CFG_IDX_W'(r), pick_weight());
            sent = 0;
            while (sent < 155)
            begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, MAX_IN)
                                                 : $urandom_range(MAX_IN + 1, MAX_IN + 3);
                for (int i = 0; i < len; i++)
                    send_operand(pick_operand(), i == len - 1, 1'b0, none);
                sent += len;
            end
        end

        calm = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (position_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ecspm_pkg.sv
rtl/core/ecspm_combine.sv
rtl/core/elementwise_combine_sum_prod_max.sv
bench/testbench.sv
